// ----- design/dsts_pkg.sv -----
// shared widths, codes and types for the disk seek total scheduler
`default_nettype none
package dsts_pkg;
	localparam int MAX_REQUESTS = 256;
	localparam int TRACK_BITS   = 16;
	localparam int SEEK_W       = 24;
	localparam int IDX_W        = $clog2(MAX_REQUESTS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_START  = 1'b1;

	typedef enum logic [1:0] {
		POL_FCFS  = 2'd0,
		POL_SSTF  = 2'd1,
		POL_LOOK  = 2'd2,
		POL_CLOOK = 2'd3
	} policy_t;

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	// closing steps of the look sweeps
	typedef enum logic [2:0] {
		FS_UP   = 3'b001,
		FS_DOWN = 3'b010,
		FS_WRAP = 3'b100
	} fin_step_t;

	typedef logic [TRACK_BITS-1:0] track_t;
	typedef logic [SEEK_W-1:0]     seek_t;
endpackage
`default_nettype wire

// ----- design/dsts_req_if.sv -----
// request channel: one track request per item
`default_nettype none
interface dsts_req_if import dsts_pkg::*; ();
	logic   valid;
	logic   ready;
	track_t track;
	logic   last;

	modport source (output valid, output track, output last, input ready);
	modport sink (input valid, input track, input last, output ready);
endinterface
`default_nettype wire

// ----- design/dsts_res_if.sv -----
// result channel: total head travel of one list per item
`default_nettype none
interface dsts_res_if import dsts_pkg::*; ();
	logic  valid;
	logic  ready;
	seek_t head_travel;
	logic  overflow;

	modport source (output valid, output head_travel, output overflow, input ready);
	modport sink (input valid, input head_travel, input overflow, output ready);
endinterface
`default_nettype wire

// ----- design/disk_seek_total_scheduler.sv -----
// disk seek total scheduler: request store, scan sequencer and shared distance unit
// requests load at one item per cycle while in the load state; after the last item a scan runs
// over the store through one distance/compare unit and one read port: one pass for FCFS, one
// pass plus closing steps for LOOK and C-LOOK, n scans of n entries each for SSTF (n stored requests)
// no item is taken from the last item until the total moves to the output register
// reset: asynchronous active low, clears control, count and drop flag; marks reload per item
`default_nettype none
module disk_seek_total_scheduler
	import dsts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	dsts_req_if.sink                   req,
	dsts_res_if.source                 res
);
	// configuration
	policy_t policy_q;
	track_t  start_q;

	// control
	state_t              state_q;
	fin_step_t           fin_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                drop_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    rnd_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;

	// datapath
	track_t           rdata_s1;
	logic             srv_s1;
	track_t           pos_q;
	seek_t            sum_q;
	logic             found_q;
	track_t           best_q;
	logic [IDX_W-1:0] pick_q;
	track_t           val_q;
	logic             hi_any_q;
	track_t           hi_max_q;
	logic             lo_any_q;
	track_t           lo_min_q;
	track_t           lo_max_q;

	// output register
	logic  out_vld_q;
	seek_t out_seek_q;
	logic  out_ovf_q;

	// request store and served marks
	track_t mem [MAX_REQUESTS];
	logic   served_mem [MAX_REQUESTS];

	logic             in_acc;
	logic             full;
	logic             issue;
	logic [CNT_W-1:0] cnt_m1;
	logic [IDX_W-1:0] last_idx;
	logic             scan_last;
	logic             is_look;
	logic             circ;
	track_t           pos_up;
	track_t           alu_a;
	track_t           alu_b;
	logic             alu_ge;
	track_t           alu_d;
	track_t           add_op;
	logic [SEEK_W:0]  sum_add;
	seek_t            sum_sat;
	logic             elem_ok;
	logic             take;
	logic             cand_found;
	track_t           cand_best;
	logic [IDX_W-1:0] cand_pick;
	track_t           cand_val;
	logic             mark_we;
	logic             emit_go;

	assign in_acc    = req.valid && req.ready;
	assign req.ready = (state_q == ST_LOAD);
	assign full      = (cnt_q == CNT_W'(MAX_REQUESTS));
	assign issue     = (state_q == ST_SCAN) && (idx_q != cnt_q);
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign last_idx  = cnt_m1[IDX_W-1:0];
	assign scan_last = rd_vld_s1 && (rd_idx_s1 == last_idx);
	assign is_look   = (policy_q == POL_LOOK) || (policy_q == POL_CLOOK);
	assign circ      = (policy_q == POL_CLOOK);
	assign pos_up    = hi_any_q ? hi_max_q : start_q;
	assign emit_go   = (state_q == ST_EMIT) && (!out_vld_q || res.ready);

	// shared distance unit operand select
	always_comb begin
		alu_a = rdata_s1;
		alu_b = is_look ? start_q : pos_q;
		if (state_q == ST_FIN) begin
			case (fin_q)
				FS_UP: begin
					alu_a = pos_up;
					alu_b = start_q;
				end
				FS_DOWN: begin
					alu_a = pos_q;
					alu_b = lo_min_q;
				end
				FS_WRAP: begin
					alu_a = lo_max_q;
					alu_b = lo_min_q;
				end
				default: begin
					alu_a = pos_q;
					alu_b = pos_q;
				end
			endcase
		end
	end

	// absolute distance and saturating accumulate
	assign alu_ge  = (alu_a >= alu_b);
	assign alu_d   = alu_ge ? (alu_a - alu_b) : (alu_b - alu_a);
	assign add_op  = (state_q == ST_SCAN && policy_q == POL_SSTF) ? cand_best : alu_d;
	assign sum_add = {1'b0, sum_q} + {{(SEEK_W + 1 - TRACK_BITS){1'b0}}, add_op};
	assign sum_sat = sum_add[SEEK_W] ? {SEEK_W{1'b1}} : sum_add[SEEK_W-1:0];

	// nearest-candidate update for shortest seek first
	assign elem_ok    = rd_vld_s1 && !srv_s1;
	assign take       = elem_ok && (!found_q || (alu_d < best_q));
	assign cand_found = found_q || elem_ok;
	assign cand_best  = take ? alu_d : best_q;
	assign cand_pick  = take ? rd_idx_s1 : pick_q;
	assign cand_val   = take ? rdata_s1 : val_q;
	assign mark_we    = (state_q == ST_SCAN) && (policy_q == POL_SSTF) && scan_last && cand_found;

	// store write and registered read
	always_ff @(posedge clk) begin
		if (in_acc && !full) begin
			mem[cnt_q[IDX_W-1:0]] <= req.track;
		end
		if (issue) begin
			rdata_s1 <= mem[idx_q[IDX_W-1:0]];
		end
	end

	// served marks: cleared as each request loads, set when shortest seek first serves it
	always_ff @(posedge clk) begin
		if (in_acc && !full) begin
			served_mem[cnt_q[IDX_W-1:0]] <= 1'b0;
		end else if (mark_we) begin
			served_mem[cand_pick] <= 1'b1;
		end
		if (issue) begin
			srv_s1 <= served_mem[idx_q[IDX_W-1:0]];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FCFS;
			start_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_POLICY: policy_q <= policy_t'(cfg_wdata[1:0]);
				REG_START:  start_q  <= cfg_wdata[TRACK_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			fin_q      <= FS_UP;
			cnt_q      <= '0;
			drop_q     <= 1'b0;
			idx_q      <= '0;
			rnd_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			pos_q      <= '0;
			sum_q      <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			pick_q     <= '0;
			val_q      <= '0;
			hi_any_q   <= 1'b0;
			hi_max_q   <= '0;
			lo_any_q   <= 1'b0;
			lo_min_q   <= '0;
			lo_max_q   <= '0;
			out_vld_q  <= 1'b0;
			out_seek_q <= '0;
			out_ovf_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			rd_idx_s1 <= idx_q[IDX_W-1:0];
			if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			// output valid: set on hand-over, cleared once taken
			if (emit_go) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (req.last) begin
							state_q  <= ST_SCAN;
							idx_q    <= '0;
							rnd_q    <= '0;
							sum_q    <= '0;
							pos_q    <= start_q;
							found_q  <= 1'b0;
							hi_any_q <= 1'b0;
							lo_any_q <= 1'b0;
							fin_q    <= FS_UP;
						end
					end
				end

				ST_SCAN: begin
					if (cnt_q == '0) begin
						state_q <= is_look ? ST_FIN : ST_EMIT;
					end else begin
						case (policy_q)
							POL_FCFS: begin
								if (rd_vld_s1) begin
									sum_q <= sum_sat;
									pos_q <= rdata_s1;
								end
								if (scan_last) begin
									state_q <= ST_EMIT;
								end
							end
							POL_SSTF: begin
								if (scan_last) begin
									found_q <= 1'b0;
									if (cand_found) begin
										sum_q <= sum_sat;
										pos_q <= cand_val;
									end
									if (rnd_q == cnt_m1) begin
										state_q <= ST_EMIT;
									end else begin
										rnd_q <= rnd_q + CNT_W'(1);
										idx_q <= '0;
									end
								end else if (rd_vld_s1) begin
									found_q <= cand_found;
									best_q  <= cand_best;
									pick_q  <= cand_pick;
									val_q   <= cand_val;
								end
							end
							default: begin
								// split into requests at or above the start track and below it
								if (rd_vld_s1) begin
									if (alu_ge) begin
										hi_any_q <= 1'b1;
										if (!hi_any_q || rdata_s1 > hi_max_q) begin
											hi_max_q <= rdata_s1;
										end
									end else begin
										lo_any_q <= 1'b1;
										if (!lo_any_q || rdata_s1 < lo_min_q) begin
											lo_min_q <= rdata_s1;
										end
										if (!lo_any_q || rdata_s1 > lo_max_q) begin
											lo_max_q <= rdata_s1;
										end
									end
								end
								if (scan_last) begin
									state_q <= ST_FIN;
								end
							end
						endcase
					end
				end

				ST_FIN: begin
					case (fin_q)
						FS_UP: begin
							sum_q <= sum_sat;
							pos_q <= pos_up;
							fin_q <= FS_DOWN;
						end
						FS_DOWN: begin
							if (lo_any_q) begin
								sum_q <= sum_sat;
							end
							if (circ) begin
								fin_q <= FS_WRAP;
							end else begin
								state_q <= ST_EMIT;
							end
						end
						default: begin
							if (lo_any_q) begin
								sum_q <= sum_sat;
							end
							state_q <= ST_EMIT;
						end
					endcase
				end

				ST_EMIT: begin
					// hand the total to the output register and clear the list
					if (emit_go) begin
						out_seek_q <= sum_q;
						out_ovf_q  <= drop_q;
						cnt_q      <= '0;
						drop_q     <= 1'b0;
						state_q    <= ST_LOAD;
					end
				end

				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign res.valid       = out_vld_q;
	assign res.head_travel = out_seek_q;
	assign res.overflow    = out_ovf_q;

	// checks
	a_last_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req.last) |=> (state_q == ST_SCAN))
		else $error("last item did not start a scan");

	a_emit_clears_list: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (cnt_q == '0 && !drop_q && out_vld_q))
		else $error("list state not cleared on result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_REQUESTS))
		else $error("request count beyond store depth");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && policy_q == POL_SSTF && cnt_q != '0) |-> (rnd_q < cnt_q))
		else $error("more rounds than stored requests");
endmodule
`default_nettype wire
